// ===== hw/rtl/dlie_pkg.sv =====
// ----------------------------------------------------------------------------
// dlie_pkg
// shared constants, types and state codes of the dataflow level ilp estimator
// ----------------------------------------------------------------------------
package dlie_pkg;

  // default sizing
  localparam int NUM_RESOURCES_DEF = 64;
  localparam int MAX_BLOCK_LEN_DEF = 1023;

  // fixed field widths
  localparam int MASK_W = 64;
  localparam int OUT_W  = 10;

  // lanes reduced together in the first merge step
  localparam int LANES_PER_GROUP = 8;

  // lane update control
  typedef struct packed {
    logic upd;   // raise levels to the new set number
    logic clr;   // end of block, zero both levels
  } lane_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/dlie_ifs.sv =====
// ----------------------------------------------------------------------------
// dlie channel interfaces
// instruction channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dlie_in_if;
  logic                       valid;
  logic                       ready;
  logic [dlie_pkg::MASK_W-1:0] read_mask;
  logic [dlie_pkg::MASK_W-1:0] write_mask;
  logic                       is_float;
  logic                       last_in_block;

  modport source (output valid, read_mask, write_mask, is_float, last_in_block,
                  input ready);
  modport sink   (input valid, read_mask, write_mask, is_float, last_in_block,
                  output ready);
endinterface

interface dlie_out_if;
  logic                      valid;
  logic                      ready;
  logic [dlie_pkg::OUT_W-1:0] set_number;
  logic                      block_done;
  logic [dlie_pkg::OUT_W-1:0] block_size;
  logic [dlie_pkg::OUT_W-1:0] set_count;
  logic [dlie_pkg::OUT_W-1:0] float_count;

  modport source (output valid, set_number, block_done, block_size, set_count,
                  float_count, input ready);
  modport sink   (input valid, set_number, block_done, block_size, set_count,
                  float_count, output ready);
endinterface

// ===== hw/rtl/dataflow_level_ilp_estimator_top.sv =====
// ----------------------------------------------------------------------------
// dataflow_level_ilp_estimator_top
// asap dataflow level scheduling of a basic block, one lane per resource
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | transfer
//  item    | in  | read_mask, write_mask, is_float, last_in_block | valid & ready
//  result  | out | set_number, block_done, block_size, set_count, | valid & ready
//          |     | float_count                                    |
//
//  steps: the transfer cycle forms each lane's bound and the registered group
//    maxima; the merge state then merges the groups, raises the lane levels
//    and loads the result register; the next instruction waits until it ends
//  reset: synchronous, clears all lane levels, counters and the sequencer
//  stalls: an instruction is taken while a result still waits; its merge
//    step holds until the result register is free
//  a block-ending instruction reports the totals and clears all levels
// ----------------------------------------------------------------------------
module dataflow_level_ilp_estimator_top #(
  parameter int NUM_RESOURCES = dlie_pkg::NUM_RESOURCES_DEF,
  parameter int MAX_BLOCK_LEN = dlie_pkg::MAX_BLOCK_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dlie_in_if.sink           item,
  dlie_out_if.source        result
);

  // level width and bound width (one more bit for level + 1)
  localparam int LVL_W = $clog2(MAX_BLOCK_LEN + 1);
  localparam int CW    = LVL_W + 1;
  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_BLOCK_LEN);

  dlie_pkg::state_t state;

  // captured instruction
  logic [NUM_RESOURCES-1:0] rmask_q;
  logic [NUM_RESOURCES-1:0] wmask_q;
  logic                     fp_q;
  logic                     last_q;

  // block totals
  logic [LVL_W-1:0] max_level;
  logic [LVL_W-1:0] instr_count;
  logic [LVL_W-1:0] fp_count;

  // result register
  logic                       out_valid;
  logic [dlie_pkg::OUT_W-1:0] set_number;
  logic                       block_done;
  logic [dlie_pkg::OUT_W-1:0] block_size;
  logic [dlie_pkg::OUT_W-1:0] set_count;
  logic [dlie_pkg::OUT_W-1:0] float_count;

  logic accept;
  logic advance;

  logic [CW-1:0]    cand [NUM_RESOURCES];
  logic [CW-1:0]    merged;
  logic [LVL_W-1:0] lvl;
  logic [LVL_W-1:0] instr_next;
  logic [LVL_W-1:0] fp_next;
  logic [LVL_W-1:0] max_next;

  dlie_pkg::lane_ctrl_t lane_ctrl;

  assign item.ready = (state == dlie_pkg::ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign advance    = (state == dlie_pkg::ST_MERGE) && (!out_valid || result.ready);

  assign lane_ctrl.upd = advance;
  assign lane_ctrl.clr = last_q;

  // one lane per tracked resource, bounds from the live payload
  for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_lane
    dlie_lane #(
      .LVL_W (LVL_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .cand_rd (item.read_mask[r]),
      .cand_wr (item.write_mask[r]),
      .upd_rd  (rmask_q[r]),
      .upd_wr  (wmask_q[r]),
      .ctrl    (lane_ctrl),
      .lvl     (lvl),
      .cand    (cand[r])
    );
  end

  dlie_merge #(
    .NUM_LANES (NUM_RESOURCES),
    .CW        (CW)
  ) u_merge (
    .clk    (clk),
    .load   (accept),
    .cand   (cand),
    .merged (merged)
  );

  // set number: at least 1, saturating
  always_comb begin
    if (merged == '0) begin
      lvl = LVL_W'(1);
    end else if (merged > {1'b0, MAX_LVL}) begin
      lvl = MAX_LVL;
    end else begin
      lvl = merged[LVL_W-1:0];
    end
  end

  assign instr_next = (instr_count == MAX_LVL) ? instr_count : instr_count + 1'b1;
  assign fp_next    = (fp_q && (fp_count != MAX_LVL)) ? fp_count + 1'b1 : fp_count;
  assign max_next   = (lvl > max_level) ? lvl : max_level;

  // output fields keep the low bits of a level
  function automatic logic [dlie_pkg::OUT_W-1:0] to_out(input logic [LVL_W-1:0] v);
    logic [31:0] wide;
    wide   = 32'(v);
    to_out = wide[dlie_pkg::OUT_W-1:0];
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlie_pkg::ST_IDLE;
    end else begin
      case (state)
        dlie_pkg::ST_IDLE: begin
          if (accept) begin
            state <= dlie_pkg::ST_MERGE;
          end
        end
        dlie_pkg::ST_MERGE: begin
          if (advance) begin
            state <= dlie_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= dlie_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // instruction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      rmask_q <= item.read_mask[NUM_RESOURCES-1:0];
      wmask_q <= item.write_mask[NUM_RESOURCES-1:0];
      fp_q    <= item.is_float;
      last_q  <= item.last_in_block;
    end
  end

  // block totals, cleared after a block-ending instruction
  always_ff @(posedge clk) begin
    if (rst || (advance && last_q)) begin
      max_level   <= '0;
      instr_count <= '0;
      fp_count    <= '0;
    end else if (advance) begin
      max_level   <= max_next;
      instr_count <= instr_next;
      fp_count    <= fp_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      set_number <= to_out(lvl);
      block_done <= last_q;
      if (last_q) begin
        block_size  <= to_out(instr_next);
        set_count   <= to_out(max_next);
        float_count <= to_out(fp_next);
      end else begin
        block_size  <= '0;
        set_count   <= '0;
        float_count <= '0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.set_number  = set_number;
  assign result.block_done  = block_done;
  assign result.block_size  = block_size;
  assign result.set_count   = set_count;
  assign result.float_count = float_count;

`ifndef ASSERT_OFF
  // a taken instruction always moves on to its merge cycle
  a_accept_merge: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == dlie_pkg::ST_MERGE))
    else $error("instruction transfer did not enter merge");

  // a fresh result only comes out of a merge cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == dlie_pkg::ST_MERGE))
    else $error("result appeared without a merge cycle");

  // totals are zero on results inside a block
  a_open_block_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !block_done) |->
      (block_size == '0 && set_count == '0 && float_count == '0))
    else $error("totals reported before end of block");

  // a finished block leaves cleared totals behind
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && last_q) |=>
      (instr_count == '0 && max_level == '0 && fp_count == '0))
    else $error("block totals not cleared");
`endif

endmodule

// ===== hw/rtl/dlie_lane.sv =====
// ----------------------------------------------------------------------------
// dlie_lane
// one resource: holds its read and write levels, forms its dependency bound
// ----------------------------------------------------------------------------
module dlie_lane #(
  parameter int LVL_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cand_rd,
  input  logic                 cand_wr,
  input  logic                 upd_rd,
  input  logic                 upd_wr,
  input  dlie_pkg::lane_ctrl_t ctrl,
  input  logic [LVL_W-1:0]     lvl,
  output logic [LVL_W:0]       cand
);

  logic [LVL_W-1:0] read_level;
  logic [LVL_W-1:0] write_level;
  logic [LVL_W:0]   rl_inc;
  logic [LVL_W:0]   wl_inc;

  assign rl_inc = {1'b0, read_level} + 1'b1;
  assign wl_inc = {1'b0, write_level} + 1'b1;

  // raw, war and waw bounds
  always_comb begin
    cand = '0;
    if (cand_rd || cand_wr) begin
      cand = wl_inc;
    end
    if (cand_wr && (rl_inc > cand)) begin
      cand = rl_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctrl.upd && ctrl.clr)) begin
      read_level  <= '0;
      write_level <= '0;
    end else if (ctrl.upd) begin
      if (upd_rd && (lvl > read_level)) begin
        read_level <= lvl;
      end
      if (upd_wr && (lvl > write_level)) begin
        write_level <= lvl;
      end
    end
  end

endmodule

// ===== hw/rtl/dlie_merge.sv =====
// ----------------------------------------------------------------------------
// dlie_merge
// two-step max over lane bounds: registered group maxima, then group merge
// ----------------------------------------------------------------------------
module dlie_merge #(
  parameter int NUM_LANES = 64,
  parameter int CW        = 11
) (
  input  logic          clk,
  input  logic          load,
  input  logic [CW-1:0] cand [NUM_LANES],
  output logic [CW-1:0] merged
);

  localparam int G          = dlie_pkg::LANES_PER_GROUP;
  localparam int NUM_GROUPS = (NUM_LANES + G - 1) / G;

  logic [CW-1:0] grp_comb [NUM_GROUPS];
  logic [CW-1:0] grp      [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_comb[g] = '0;
      for (int k = 0; k < G; k++) begin
        if ((g * G + k) < NUM_LANES) begin
          if (cand[g * G + k] > grp_comb[g]) begin
            grp_comb[g] = cand[g * G + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp[g] <= grp_comb[g];
      end
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp[g] > merged) begin
        merged = grp[g];
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the dataflow level ilp estimator against its own level scheduler:
// a short table of instruction patterns, random basic blocks with idle gaps
// on both channels, a long result stall, a full drain and a dependency chain
// ----------------------------------------------------------------------------
module tb;

  localparam int MASK_W     = dlie_pkg::MASK_W;
  localparam int OUT_W      = dlie_pkg::OUT_W;
  localparam int NUM_RES    = dlie_pkg::NUM_RESOURCES_DEF;
  localparam int MAX_LEN    = dlie_pkg::MAX_BLOCK_LEN_DEF;
  localparam int NUM_FLAGS  = 11;            // flag bits sit above the registers
  localparam int FLAG_BASE  = NUM_RES - NUM_FLAGS;
  localparam int RAND_ITEMS = 400;
  localparam int CHAIN_LEN  = 32;            // one block with a long dependency chain
  localparam int HOLD_LEN   = 300;           // long result stall, in cycles
  localparam int WATCHDOG   = 2000;          // cycles with no transfer at all
  localparam int MAX_REPORT = 10;

  // one result item, packed in port order
  typedef struct packed {
    logic [OUT_W-1:0] set_number;
    logic             block_done;
    logic [OUT_W-1:0] block_size;
    logic [OUT_W-1:0] set_count;
    logic [OUT_W-1:0] float_count;
  } sched_res_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    logic [MASK_W-1:0] rmask;
    logic [MASK_W-1:0] wmask;
    logic              fp;
    logic              last;
    bit                typed;
    sched_res_t        res;
  } instr_row_t;

  logic clk = 1'b0;
  logic rst;

  dlie_in_if  item_if ();
  dlie_out_if res_if ();

  dataflow_level_ilp_estimator_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_if),
    .result(res_if)
  );

  always #5 clk = ~clk;

  // scheduler state kept by the testbench
  logic [OUT_W-1:0] lv_read  [NUM_RES];
  logic [OUT_W-1:0] lv_write [NUM_RES];
  logic [OUT_W-1:0] top_level;
  logic [OUT_W-1:0] n_instr;
  logic [OUT_W-1:0] n_fp;

  sched_res_t expected_sched [$];
  instr_row_t dir_rows [$];

  int  mismatches = 0;
  bit  steady     = 1'b0;  // no idling on either side while set
  bit  hold_req   = 1'b0;  // asks the result side for one long stall

  function automatic int unsigned sat_len(int unsigned v);
    return (v > MAX_LEN) ? MAX_LEN : v;
  endfunction

  function automatic void clear_levels();
    for (int k = 0; k < NUM_RES; k++) begin
      lv_read[k]  = '0;
      lv_write[k] = '0;
    end
    top_level = '0;
    n_instr   = '0;
    n_fp      = '0;
  endfunction

  // asap level of one instruction, then raise the touched levels to it
  function automatic sched_res_t schedule_instr(logic [MASK_W-1:0] rmask,
                                                logic [MASK_W-1:0] wmask,
                                                logic fp, logic last);
    int unsigned lvl;
    sched_res_t  r;
    lvl = 1;
    for (int k = 0; k < NUM_RES; k++) begin
      // read after write
      if (rmask[k] && int'(lv_write[k]) + 1 > lvl) lvl = int'(lv_write[k]) + 1;
      if (wmask[k]) begin
        // write after read, write after write
        if (int'(lv_read[k]) + 1 > lvl)  lvl = int'(lv_read[k]) + 1;
        if (int'(lv_write[k]) + 1 > lvl) lvl = int'(lv_write[k]) + 1;
      end
    end
    lvl = sat_len(lvl);
    for (int k = 0; k < NUM_RES; k++) begin
      if (rmask[k] && lvl > lv_read[k])  lv_read[k]  = lvl[OUT_W-1:0];
      if (wmask[k] && lvl > lv_write[k]) lv_write[k] = lvl[OUT_W-1:0];
    end
    if (lvl > top_level) top_level = lvl[OUT_W-1:0];
    n_instr = OUT_W'(sat_len(int'(n_instr) + 1));
    if (fp) n_fp = OUT_W'(sat_len(int'(n_fp) + 1));

    r = '0;
    r.set_number = lvl[OUT_W-1:0];
    if (last) begin
      // totals include this instruction, then the block starts over
      r.block_done  = 1'b1;
      r.block_size  = n_instr;
      r.set_count   = top_level;
      r.float_count = n_fp;
      clear_levels();
    end
    return r;
  endfunction

  task automatic add_row(logic [MASK_W-1:0] rmask, logic [MASK_W-1:0] wmask,
                         logic fp, logic last, bit typed, sched_res_t res);
    instr_row_t row;
    row.rmask = rmask;
    row.wmask = wmask;
    row.fp    = fp;
    row.last  = last;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // offer one instruction and hold it until the transfer; valid stays high
  task automatic send_instr(logic [MASK_W-1:0] rmask, logic [MASK_W-1:0] wmask,
                            logic fp, logic last, bit typed, sched_res_t res);
    sched_res_t pred;
    item_if.valid         <= 1'b1;
    item_if.read_mask     <= rmask;
    item_if.write_mask    <= wmask;
    item_if.is_float      <= fp;
    item_if.last_in_block <= last;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    // the predictor always runs so its state follows the block
    pred = schedule_instr(rmask, wmask, fp, last);
    expected_sched.push_back(typed ? res : pred);
  endtask

  // random idle cycles on the instruction side
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 11) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop offering until every result is back
  task automatic drain_results();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_sched.size() != 0) @(posedge clk);
  endtask

  // masks: mostly a few bits among hot registers and flags so that
  // dependencies chain, sometimes dense or extreme
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    int                kind;
    kind = $urandom_range(0, 9);
    m    = '0;
    case (kind)
      0: m = '0;
      1: m = '1;
      2, 3: m = {$urandom, $urandom};
      default: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: m[$urandom_range(0, 7)] = 1'b1;
            1: m[$urandom_range(FLAG_BASE, NUM_RES - 1)] = 1'b1;
            default: m[$urandom_range(0, NUM_RES - 1)] = 1'b1;
          endcase
        end
      end
    endcase
    return m;
  endfunction

  // result side: random ready, one long stall on request
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 11);
        @(posedge clk);
      end
    end
  end

  // result checker, compares each transfer with the oldest expectation
  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.set_number  = res_if.set_number;
      got.block_done  = res_if.block_done;
      got.block_size  = res_if.block_size;
      got.set_count   = res_if.set_count;
      got.float_count = res_if.float_count;
      if (expected_sched.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected result: set %0d done %0d size %0d sets %0d fp %0d",
                   got.set_number, got.block_done, got.block_size,
                   got.set_count, got.float_count);
      end else begin
        want = expected_sched.pop_front();
        if (got.set_number !== want.set_number || got.block_done !== want.block_done
            || got.block_size !== want.block_size || got.set_count !== want.set_count
            || got.float_count !== want.float_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("mismatch: expected set %0d done %0d size %0d sets %0d fp %0d",
                     want.set_number, want.block_done, want.block_size,
                     want.set_count, want.float_count,
                     ", got set %0d done %0d size %0d sets %0d fp %0d",
                     got.set_number, got.block_done, got.block_size,
                     got.set_count, got.float_count);
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves a transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // stimulus
  initial begin
    int sent;
    int next_pause;
    int blk_len;
    bit hold_done;
    logic [MASK_W-1:0] chain;

    rst                   <= 1'b1;
    item_if.valid         <= 1'b0;
    item_if.read_mask     <= '0;
    item_if.write_mask    <= '0;
    item_if.is_float      <= 1'b0;
    item_if.last_in_block <= 1'b0;
    clear_levels();

    // directed table; typed answers packed as set, done, size, sets, fp
    // empty instruction alone in a block, right after reset
    add_row('0, '0, 1'b0, 1'b1, 1'b1, {10'd1, 1'b1, 10'd1, 10'd1, 10'd0});
    // every resource read and written, float, alone in a block
    add_row('1, '1, 1'b1, 1'b1, 1'b1, {10'd1, 1'b1, 10'd1, 10'd1, 10'd1});
    // read after write, write after read, write after write on a register
    add_row('0, 64'h1, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'h1, 64'h2, 1'b0, 1'b0, 1'b0, '0);
    add_row('0, 64'h1, 1'b0, 1'b0, 1'b0, '0);
    add_row('0, 64'h1, 1'b1, 1'b0, 1'b0, '0);
    // flag resources chain like registers
    add_row(64'h1 << (NUM_RES - 1), 64'h1 << (NUM_RES - 1), 1'b0, 1'b0, 1'b0, '0);
    add_row(64'h1 << (NUM_RES - 1), 64'h1 << FLAG_BASE, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'h1 << FLAG_BASE, 64'h1 << FLAG_BASE, 1'b0, 1'b0, 1'b0, '0);
    // wide masks pick up the highest level anywhere
    add_row('1, '0, 1'b1, 1'b0, 1'b0, '0);
    add_row('0, '1, 1'b1, 1'b0, 1'b0, '0);
    add_row('0, '0, 1'b1, 1'b1, 1'b0, '0);
    // state is clear again after a block end
    add_row('1, '0, 1'b0, 1'b1, 1'b1, {10'd1, 1'b1, 10'd1, 10'd1, 10'd0});
    // alternating bits and halves
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, '0);
    add_row('0, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_instr(dir_rows[i].rmask, dir_rows[i].wmask, dir_rows[i].fp,
                 dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
      sender_gap();
    end

    // random basic blocks
    sent       = 0;
    next_pause = 100;
    hold_done  = 1'b0;
    while (sent < RAND_ITEMS) begin
      steady = (sent >= 150 && sent < 260);
      if (sent >= 300 && !hold_done) begin
        // the result side stalls while instructions keep coming
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (sent >= next_pause) begin
        drain_results();
        next_pause += 300;
      end
      blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                            : $urandom_range(1, 24);
      for (int j = 0; j < blk_len; j++) begin
        send_instr(pick_mask(), pick_mask(), 1'($urandom_range(0, 1)),
                   (j == blk_len - 1), 1'b0, '0);
        sender_gap();
        sent++;
      end
    end
    steady = 1'b0;

    // one dependent chain through a register and a flag, all float
    chain = 64'h1 | (64'h1 << (NUM_RES - 1));
    for (int j = 0; j < CHAIN_LEN; j++) begin
      send_instr(chain, chain, 1'b1, (j == CHAIN_LEN - 1), 1'b0, '0);
      sender_gap();
    end
    // the block after the chain starts from scratch
    send_instr('1, '1, 1'b0, 1'b1, 1'b0, '0);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dlie_pkg.sv
hw/rtl/dlie_ifs.sv
hw/rtl/dlie_lane.sv
hw/rtl/dlie_merge.sv
hw/rtl/dataflow_level_ilp_estimator_top.sv
tb/tb.sv
